// File: rtl/isp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isp_pkg;

  // Longest string the position counter tracks before it saturates
  localparam int unsigned MAX_LEN = 256;
  localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  localparam int unsigned CH_W = 8;
  localparam int unsigned BASE_W = 6;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned END_W = 9;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;

  // Packed widths on the stream ports
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_FIELDS_W = ACC_W + END_W + 2;
  localparam int unsigned OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_START  = 3'd1,
    PH_ZERO   = 3'd2,
    PH_XSEEN  = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic              negative;
    logic [ACC_W-1:0]  acc;
    logic [BASE_W-1:0] base;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  digits_end;
    logic              overflowed;
  } parse_t;

  localparam parse_t PARSE_RESET = '{
    phase:      PH_WS,
    negative:   1'b0,
    acc:        '0,
    base:       '0,
    position:   '0,
    digits_end: '0,
    overflowed: 1'b0
  };

  // Result before the sign is applied
  typedef struct packed {
    logic [ACC_W-1:0] magnitude;
    logic             negative;
    logic [END_W-1:0] end_index;
    logic             error;
    logic             overflow;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/isp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module isp_step (
  input  var isp_pkg::parse_t              st_i,
  input  var logic [isp_pkg::CH_W-1:0]     ch_i,
  input  var logic                         last_i,
  input  var logic [isp_pkg::BASE_W-1:0]   radix_i,
  output isp_pkg::parse_t                  st_o,
  output isp_pkg::result_t                 res_o
);

  localparam logic [isp_pkg::CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [isp_pkg::CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [isp_pkg::CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [isp_pkg::CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [isp_pkg::CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [isp_pkg::CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [isp_pkg::CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [isp_pkg::CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [isp_pkg::CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [isp_pkg::CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [isp_pkg::CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [isp_pkg::CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [isp_pkg::CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [isp_pkg::BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [isp_pkg::BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [isp_pkg::BASE_W-1:0] BASE_HEX = 6'd16;
  localparam logic [isp_pkg::BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [isp_pkg::BASE_W-1:0] BASE_ONE = 6'd1;
  localparam logic [isp_pkg::CH_W-1:0] LETTER_OFS = 8'd10;
  localparam int unsigned PROD_W = isp_pkg::ACC_W + isp_pkg::BASE_W;

  function automatic logic [isp_pkg::BASE_W-1:0] digit_of(logic [isp_pkg::CH_W-1:0] c);
    logic [isp_pkg::CH_W-1:0] v;
    v = {2'b10, isp_pkg::BASE_MAX};
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      v = c - CH_LA + LETTER_OFS;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      v = c - CH_UA + LETTER_OFS;
    end else begin
      v = {2'b00, isp_pkg::BASE_MAX};
    end
    return v[isp_pkg::BASE_W-1:0];
  endfunction

  function automatic logic base_bad(logic [isp_pkg::BASE_W-1:0] b);
    return (b == BASE_ONE) || (b > isp_pkg::BASE_MAX);
  endfunction

  function automatic logic [isp_pkg::POS_W-1:0] sat_next(logic [isp_pkg::POS_W-1:0] p);
    return (p >= isp_pkg::POS_MAX) ? isp_pkg::POS_MAX : p + 1'b1;
  endfunction

  function automatic logic [isp_pkg::END_W-1:0] to_end(logic [isp_pkg::POS_W-1:0] p);
    logic [isp_pkg::POS_W+isp_pkg::END_W-1:0] ext;
    ext = {{isp_pkg::END_W{1'b0}}, p};
    return ext[isp_pkg::END_W-1:0];
  endfunction

  isp_pkg::parse_t          n;
  isp_pkg::phase_e          ph;
  logic [isp_pkg::BASE_W-1:0] base;
  logic [isp_pkg::BASE_W-1:0] tbase;
  logic [isp_pkg::BASE_W-1:0] dig;
  logic                     start_num;
  logic                     take;
  logic [PROD_W-1:0]        prod;
  logic                     res_err;

  assign dig = digit_of(ch_i);

  always_comb begin
    ph = st_i.phase;
    base = st_i.base;
    // Latch the base on the first byte of a string
    if (st_i.position == '0 && st_i.phase == isp_pkg::PH_WS) begin
      base = radix_i;
      if (base_bad(radix_i)) begin
        ph = isp_pkg::PH_DONE;
      end
    end

    n = st_i;
    n.phase = ph;
    n.base = base;
    start_num = 1'b0;
    take = 1'b0;
    tbase = base;

    case (ph)
      isp_pkg::PH_WS: begin
        if (ch_i == CH_SPACE || (ch_i >= CH_TAB && ch_i <= CH_CR)) begin
          n.phase = isp_pkg::PH_WS;
        end else if (ch_i == CH_PLUS || ch_i == CH_MINUS) begin
          n.negative = (ch_i == CH_MINUS);
          n.phase = isp_pkg::PH_START;
        end else begin
          start_num = 1'b1;
        end
      end
      isp_pkg::PH_START: begin
        start_num = 1'b1;
      end
      isp_pkg::PH_ZERO: begin
        if (ch_i == CH_LX || ch_i == CH_UX) begin
          n.base = BASE_HEX;
          n.phase = isp_pkg::PH_XSEEN;
        end else begin
          tbase = (base == '0) ? BASE_OCT : base;
          n.base = tbase;
          take = 1'b1;
        end
      end
      isp_pkg::PH_XSEEN, isp_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        n.phase = ph;
      end
    endcase

    if (start_num) begin
      if (ch_i == CH_ZERO && (base == '0 || base == BASE_HEX)) begin
        n.acc = '0;
        n.digits_end = sat_next(st_i.position);
        n.phase = isp_pkg::PH_ZERO;
      end else begin
        tbase = (base == '0) ? BASE_DEC : base;
        n.base = tbase;
        take = 1'b1;
      end
    end

    // One multiply-add per byte; carry bits above 64 flag overflow
    prod = {{isp_pkg::BASE_W{1'b0}}, st_i.acc} * {{isp_pkg::ACC_W{1'b0}}, tbase}
         + {{isp_pkg::ACC_W{1'b0}}, dig};

    if (take) begin
      if (tbase < BASE_MIN || dig >= tbase) begin
        n.phase = isp_pkg::PH_DONE;
      end else begin
        n.overflowed = st_i.overflowed | (|prod[PROD_W-1:isp_pkg::ACC_W]);
        n.acc = prod[isp_pkg::ACC_W-1:0];
        n.digits_end = sat_next(st_i.position);
        n.phase = isp_pkg::PH_DIGITS;
      end
    end

    n.position = sat_next(st_i.position);

    res_err = base_bad(n.base);
    res_o.error = res_err;
    res_o.magnitude = res_err ? '0 : n.acc;
    res_o.negative = n.negative & ~res_err;
    res_o.end_index = res_err ? '0 : to_end(n.digits_end);
    res_o.overflow = n.overflowed & ~res_err;

    // A string ends here: start the next one from scratch
    st_o = last_i ? isp_pkg::PARSE_RESET : n;
  end

endmodule

`default_nettype wire

// File: rtl/integer_string_parser.sv
`timescale 1ns / 1ps
// Streaming integer parser, bases 2 to 36, one byte of a string per beat.
// Slave channel: s_axis_tdata[7:0] carries the byte, s_axis_tlast marks the
// final byte of the string. Each string produces exactly one result beat on
// the master channel when its final byte has been parsed; other bytes give no
// output. Master tdata holds the signed value (two's complement, wrapping
// modulo 2^64), the count of bytes up to the last digit, an invalid-base
// error flag and an overflow flag.
// cfg_we_i/cfg_wdata_i write the radix (0 = detect from prefix). Write it only
// while no string is in flight; each string samples it on its first byte.
// A final byte passes from the input register through the parse step into
// the output register that drives m_axis_tvalid. Throughput: one byte per
// cycle unless a final byte waits on a busy output; the per-byte step is one
// 64x6 multiply-add feeding the accumulator register.
// A stalled master side holds the result in the output register while the
// parser keeps taking bytes of the next string; only a second final byte
// waits, and then the input register backs up to s_axis_tready.
// Reset: radix returns to 10, the parser to its white-space phase, and both
// channel registers empty.
`default_nettype none

module integer_string_parser (
  input  var logic                                clk_i,
  input  var logic                                rst_ni,
  input  var logic                                s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  var logic [isp_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] ch
  input  var logic                                s_axis_tlast,  // last
  output logic                                    m_axis_tvalid,
  input  var logic                                m_axis_tready,
  // [63:0] value, [72:64] end_index, [73] error, [74] overflow, [79:75] zero
  output logic [isp_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  input  var logic                                cfg_we_i,
  input  var logic [isp_pkg::BASE_W-1:0]          cfg_wdata_i
);

  logic [isp_pkg::BASE_W-1:0] radix_q;

  logic                       in_valid_q, in_valid_d;
  logic [isp_pkg::CH_W-1:0]   ch_q;
  logic                       last_q;

  isp_pkg::parse_t            st_q, st_d;
  isp_pkg::result_t           res_d, res_q;
  logic                       out_valid_q, out_valid_d;

  logic                       s_beat;
  logic                       consume;
  logic [isp_pkg::ACC_W-1:0]  value;

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= isp_pkg::RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Parse the held byte unless it ends a string and the result slot is busy
  assign consume = in_valid_q && (!last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || consume;
  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign in_valid_d = s_beat || (in_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      ch_q   <= s_axis_tdata[isp_pkg::CH_W-1:0];
      last_q <= s_axis_tlast;
    end
  end

  isp_step u_step (
    .st_i    (st_q),
    .ch_i    (ch_q),
    .last_i  (last_q),
    .radix_i (radix_q),
    .st_o    (st_d),
    .res_o   (res_d)
  );

  // Parser state: advance on every consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= isp_pkg::PARSE_RESET;
    end else if (consume) begin
      st_q <= st_d;
    end
  end

  // Output register: load on a final byte, drop once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (consume && last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && last_q) begin
      res_q <= res_d;
    end
  end

  // Apply the sign after the register to keep the multiply path short
  assign value = res_q.negative ? ('0 - res_q.magnitude) : res_q.magnitude;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {
    {(isp_pkg::OUT_DATA_W - isp_pkg::OUT_FIELDS_W){1'b0}},
    res_q.overflow,
    res_q.error,
    res_q.end_index,
    value
  };

  // An invalid base reports nothing but the error flag
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.error) |->
      (res_q.magnitude == '0 && res_q.end_index == '0 && !res_q.overflow && !res_q.negative))
    else $error("error result carries value, index or overflow");

  // A final byte leaves the parser ready for a fresh string
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && last_q) |=>
      (st_q.phase == isp_pkg::PH_WS && st_q.position == '0 && st_q.acc == '0))
    else $error("parser state not cleared after final byte");

  // The digit end never runs ahead of the bytes seen
  a_end_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.digits_end <= st_q.position)
    else $error("digit end beyond position");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !(consume && last_q))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
